[sv/aco_pkg.sv]
`default_nettype none

package aco_pkg;

	// Matrix geometry.
	localparam int CITIES = 64;
	localparam int CELLS  = CITIES * CITIES;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CITY_W = 6;

	// Field widths fixed by the item format.
	localparam int MODE_W  = 3;
	localparam int VALUE_W = 32;
	localparam int LEVEL_W = 32;
	localparam int WEIGHT_W = 32;
	localparam int WLEVEL_W = 64;
	localparam int RATE_W  = 16;
	localparam int KEEP_W  = RATE_W + 1;
	localparam int ADD_W   = 24;

	// Operation codes.
	localparam logic [MODE_W-1:0] MODE_INIT      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_EVAP_ANT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DEP_ANT   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EVAP_BEST = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DEP_BEST  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_READ      = 3'd6;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANT_RATE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BEST_RATE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LEVEL = 2'd2;

	// Configuration reset values.
	localparam logic [RATE_W-1:0]  ANT_RATE_RST      = 16'd59638;
	localparam logic [RATE_W-1:0]  BEST_RATE_RST     = 16'd13;
	localparam logic [LEVEL_W-1:0] INITIAL_LEVEL_RST = 32'd16777;

	// Flat address of the entry at a row and a column.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [CITY_W-1:0] row,
		input logic [CITY_W-1:0] col);
		return ADDR_W'(ADDR_W'(row) * ADDR_W'(CITIES) + ADDR_W'(col));
	endfunction

endpackage

`default_nettype wire

[sv/aco_pheromone_matrix_update.sv]
// Channel   Signals                                        Handshake
// -------   --------------------------------------------   ------------------------
// command   start, mode, city_a, city_b, value             start && !busy
// result    done, pheromone_level, weighted_level          done, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data      cfg_valid && cfg_ready
//
// Sequence from acceptance to the result strobe: init sweeps the pheromone
// memory one entry per cycle through its single write port;
// evaporate sweeps the same way, with a read ahead of each write;
// deposit reads, then does one write per symmetric entry;
// read does the memory read, then the multiply; load and all other items finish when accepted.
// Reset is asynchronous, active low, and clears control and configuration;
// memory contents are undefined until init and load write them.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module aco_pheromone_matrix_update (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [aco_pkg::MODE_W-1:0]          mode,
	input  wire  [aco_pkg::CITY_W-1:0]          city_a,
	input  wire  [aco_pkg::CITY_W-1:0]          city_b,
	input  wire  [aco_pkg::VALUE_W-1:0]         value,
	output logic                                done,
	output logic [aco_pkg::LEVEL_W-1:0]         pheromone_level,
	output logic [aco_pkg::WLEVEL_W-1:0]        weighted_level,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [aco_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [31:0]                         cfg_data
);
	import aco_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_FILL     = 4'd1;
	localparam logic [3:0] ST_EVAP     = 4'd2;
	localparam logic [3:0] ST_EVAP_END = 4'd3;
	localparam logic [3:0] ST_DEP_RD   = 4'd4;
	localparam logic [3:0] ST_DEP_WR1  = 4'd5;
	localparam logic [3:0] ST_DEP_WR2  = 4'd6;
	localparam logic [3:0] ST_RD_MEM   = 4'd7;
	localparam logic [3:0] ST_RD_MUL   = 4'd8;

	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);

	logic [3:0]             state_q, state_d;
	logic [ADDR_W-1:0]      sweep_q, sweep_d;
	logic                   done_q;
	logic                   accept;
	logic                   edge_ok;
	logic                   finish;

	logic [RATE_W-1:0]      ant_rate_q;
	logic [RATE_W-1:0]      best_rate_q;
	logic [LEVEL_W-1:0]     initial_level_q;

	logic [RATE_W-1:0]      rate_sel;
	logic [RATE_W-1:0]      rate_q;
	logic [KEEP_W-1:0]      keep_q;
	logic [VALUE_W-1:0]     value_q;
	logic [ADDR_W-1:0]      ab_q;
	logic [ADDR_W-1:0]      ba_q;
	logic [ADD_W-1:0]       add_q;
	logic [LEVEL_W-1:0]     dep_level_q;
	logic [LEVEL_W-1:0]     level_q;
	logic [WLEVEL_W-1:0]    weighted_q;

	logic                   evap_vld_s1;
	logic [ADDR_W-1:0]      evap_addr_s1;

	logic [LEVEL_W-1:0]     ph_mem [CELLS];
	logic [WEIGHT_W-1:0]    wt_mem [CELLS];
	logic [LEVEL_W-1:0]     ph_rdata_q;
	logic [WEIGHT_W-1:0]    wt_rdata_q;
	logic                   ph_we;
	logic [ADDR_W-1:0]      ph_waddr;
	logic [ADDR_W-1:0]      ph_raddr;
	logic [LEVEL_W-1:0]     ph_wdata;
	logic                   wt_we;

	logic [LEVEL_W+KEEP_W-1:0]  evap_prod;
	logic [RATE_W+VALUE_W-1:0]  dep_prod;
	logic [LEVEL_W:0]           dep_sum;
	logic [LEVEL_W-1:0]         dep_sat;
	logic [LEVEL_W-1:0]         res_level;
	logic [WLEVEL_W-1:0]        res_weighted;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign edge_ok   = (int'(city_a) < CITIES) && (int'(city_b) < CITIES);

	assign done            = done_q;
	assign pheromone_level = level_q;
	assign weighted_level  = weighted_q;

	// Datapath arithmetic: evaporation scale, deposit increment and saturation.
	assign rate_sel  = (mode == MODE_EVAP_BEST || mode == MODE_DEP_BEST) ?
		best_rate_q : ant_rate_q;
	assign evap_prod = ph_rdata_q * keep_q;
	assign dep_prod  = rate_q * value_q;
	assign dep_sum   = {1'b0, ph_rdata_q} + (LEVEL_W+1)'(add_q);
	assign dep_sat   = dep_sum[LEVEL_W] ? {LEVEL_W{1'b1}} : dep_sum[LEVEL_W-1:0];

	// Sequencer and memory port control.
	always_comb begin
		state_d      = state_q;
		sweep_d      = sweep_q;
		finish       = 1'b0;
		res_level    = '0;
		res_weighted = '0;
		wt_we        = 1'b0;
		ph_raddr     = ab_q;
		ph_we        = evap_vld_s1;
		ph_waddr     = evap_addr_s1;
		ph_wdata     = evap_prod[LEVEL_W+RATE_W-1:RATE_W];

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (mode) inside
						MODE_INIT: begin
							state_d = ST_FILL;
						end
						MODE_LOAD: begin
							wt_we  = edge_ok;
							finish = 1'b1;
						end
						MODE_EVAP_ANT, MODE_EVAP_BEST: begin
							state_d = ST_EVAP;
						end
						MODE_DEP_ANT, MODE_DEP_BEST: begin
							if (edge_ok) begin
								state_d = ST_DEP_RD;
							end else begin
								finish = 1'b1;
							end
						end
						MODE_READ: begin
							if (edge_ok) begin
								state_d = ST_RD_MEM;
							end else begin
								finish = 1'b1;
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			ST_FILL: begin
				ph_we    = 1'b1;
				ph_waddr = sweep_q;
				ph_wdata = initial_level_q;
				if (sweep_q == LAST_CELL) begin
					sweep_d = '0;
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			ST_EVAP: begin
				ph_raddr = sweep_q;
				if (sweep_q == LAST_CELL) begin
					sweep_d = '0;
					state_d = ST_EVAP_END;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			ST_EVAP_END: begin
				finish  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DEP_RD: begin
				state_d = ST_DEP_WR1;
			end
			ST_DEP_WR1: begin
				ph_we    = 1'b1;
				ph_waddr = ab_q;
				ph_wdata = dep_sat;
				state_d  = ST_DEP_WR2;
			end
			ST_DEP_WR2: begin
				ph_we    = 1'b1;
				ph_waddr = ba_q;
				ph_wdata = dep_level_q;
				finish   = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_RD_MEM: begin
				state_d = ST_RD_MUL;
			end
			ST_RD_MUL: begin
				res_level    = ph_rdata_q;
				res_weighted = ph_rdata_q * wt_rdata_q;
				finish       = 1'b1;
				state_d      = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			sweep_q         <= '0;
			done_q          <= 1'b0;
			evap_vld_s1     <= 1'b0;
			ant_rate_q      <= ANT_RATE_RST;
			best_rate_q     <= BEST_RATE_RST;
			initial_level_q <= INITIAL_LEVEL_RST;
		end else begin
			state_q     <= state_d;
			sweep_q     <= sweep_d;
			done_q      <= finish;
			evap_vld_s1 <= (state_q == ST_EVAP);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ANT_RATE:      ant_rate_q      <= cfg_data[RATE_W-1:0];
					CFG_BEST_RATE:     best_rate_q     <= cfg_data[RATE_W-1:0];
					CFG_INITIAL_LEVEL: initial_level_q <= cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Item operands, pipeline payload and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			rate_q  <= rate_sel;
			keep_q  <= KEEP_W'(1 << RATE_W) - KEEP_W'(rate_sel);
			value_q <= value;
			ab_q    <= cell_addr(city_a, city_b);
			ba_q    <= cell_addr(city_b, city_a);
		end
		evap_addr_s1 <= sweep_q;
		if (state_q == ST_DEP_RD) begin
			add_q <= dep_prod[RATE_W+VALUE_W-1:ADD_W];
		end
		if (state_q == ST_DEP_WR1) begin
			dep_level_q <= dep_sat;
		end
		if (finish) begin
			level_q    <= res_level;
			weighted_q <= res_weighted;
		end
	end

	// Pheromone memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ph_we) begin
			ph_mem[ph_waddr] <= ph_wdata;
		end
		ph_rdata_q <= ph_mem[ph_raddr];
	end

	// Edge weight memory: written by load, read for the weighted level.
	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[cell_addr(city_a, city_b)] <= value;
		end
		wt_rdata_q <= wt_mem[ab_q];
	end

endmodule

`default_nettype wire

[sv/aco_checker.sv]
`default_nettype none

module aco_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            start,
	input wire                            busy,
	input wire [aco_pkg::MODE_W-1:0]      mode,
	input wire                            done
);
	import aco_pkg::*;

	// A read transaction answers only after its memory read and multiply states.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_READ) |=> !done ##1 !done ##1 done)
		else $error("read result not delivered three cycles after acceptance");

	// Every accepted transaction either keeps the block busy or answers at once.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither busy nor answered");

	// The result strobe comes only once the block has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// Leaving the busy state always delivers a result.
	a_busy_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

endmodule

bind aco_pheromone_matrix_update aco_checker u_aco_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.mode   (mode),
	.done   (done)
);

`default_nettype wire
